/* design/sorted_address_predecessor_lookup_macros.svh */
// assertion macros for the sorted address predecessor lookup checker
`ifndef SORTED_ADDRESS_PREDECESSOR_LOOKUP_MACROS_SVH
`define SORTED_ADDRESS_PREDECESSOR_LOOKUP_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define SAPL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define SAPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sapl_pkg.sv */
// shared types and constants for the sorted address predecessor lookup
package sapl_pkg;

    localparam int FIELD_BITS  = 32;
    localparam int INDEX_BITS  = 10;
    localparam logic [FIELD_BITS-1:0] LOW32_MASK = 32'hffff_ffff;

    // transaction function codes
    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FOUND     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FETCH,
        ST_RESULT
    } state_t;

    // sequencer to search unit
    typedef struct packed {
        logic start;
        logic step;
    } search_ctl_t;

    // search unit to sequencer
    typedef struct packed {
        logic more;
        logic lo_zero;
    } search_sts_t;

endpackage

/* design/sapl_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module sapl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/sapl_search.sv */
// binary search bounds unit: keeps lo/hi/mid and picks the next probe address
module sapl_search #(
    parameter int TABLE_DEPTH = 1024,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sapl_pkg::search_ctl_t        ctl,
    input  logic [CW-1:0]                total,
    input  logic [sapl_pkg::FIELD_BITS-1:0] key,
    input  logic [sapl_pkg::FIELD_BITS-1:0] rd_data,
    output sapl_pkg::search_sts_t        sts,
    output logic [IW-1:0]                rd_addr,
    output logic [IW-1:0]                hit_index
);
    import sapl_pkg::*;

    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [IW-1:0] mid_reg;
    logic [CW-1:0] mid_next;
    logic [CW-1:0] span;
    logic [CW-1:0] lo_prev_next;
    logic [CW-1:0] lo_prev_reg;
    logic          go_right;

    // probed entry at or below the key moves the lower bound past it
    assign go_right = (rd_data <= key);

    // next bounds
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctl.start)
        begin
            lo_next = '0;
            hi_next = total;
        end
        else if (ctl.step)
        begin
            if (go_right)
            begin
                lo_next = CW'(mid_reg) + CW'(1);
            end
            else
            begin
                hi_next = CW'(mid_reg);
            end
        end
    end

    // next midpoint and read address
    assign span         = hi_next - lo_next;
    assign mid_next     = lo_next + (span >> 1);
    assign lo_prev_next = lo_next - CW'(1);
    assign sts.more     = (lo_next < hi_next);
    assign sts.lo_zero  = (lo_next == '0);
    assign rd_addr      = sts.more ? mid_next[IW-1:0] : lo_prev_next[IW-1:0];

    // bound registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg      <= '0;
            hi_reg      <= '0;
            mid_reg     <= '0;
            lo_prev_reg <= '0;
        end
        else if (ctl.start || ctl.step)
        begin
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            mid_reg     <= mid_next[IW-1:0];
            lo_prev_reg <= lo_prev_next;
        end
    end

    // last entry at or below the key once the search has closed
    assign hit_index = lo_prev_reg[IW-1:0];

endmodule

/* design/sorted_address_predecessor_lookup.sv */
// Sorted address predecessor lookup, top level.
// One input channel (in_valid/in_ready, func, addr_value) takes append,
// lookup and clear transactions; one output channel (out_valid/out_ready,
// status, entry_index, entry_offset) returns exactly one result for each.
// Entry start addresses live in a single synchronous ram of TABLE_DEPTH words
// with registered read data; the entry count sits in a register.
// Append and clear go from acceptance straight to the result state.
// A lookup runs about ceil(log2(entries + 1)) binary-search probes in ST_PROBE,
// then, if an entry matches, one read of it in ST_FETCH, and hands the result
// over in ST_RESULT. The probe loop is bounded by the ram's single read port,
// one probe per cycle.
// One transaction is worked on at a time; in_ready is high only between them.
// A finished result waits in the output register while the next transaction
// is accepted; if the receiver stalls, the following result holds back until
// the output register is taken.
// Reset empties the table (entry count zero); ram contents are not cleared.
module sorted_address_predecessor_lookup #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ADDR_BITS   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [sapl_pkg::FIELD_BITS-1:0]     addr_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [sapl_pkg::INDEX_BITS-1:0]     entry_index,
    output logic [sapl_pkg::FIELD_BITS-1:0]     entry_offset
);
    import sapl_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [FIELD_BITS-1:0] ADDR_MASK = (ADDR_BITS >= FIELD_BITS) ? LOW32_MASK
        : FIELD_BITS'((64'd1 << ADDR_BITS) - 64'd1);

    state_t                 state_reg, state_next;
    logic [CW-1:0]          total_reg, total_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0]  key_reg, key_next;
    status_t                res_status_reg, res_status_next;
    logic [IW-1:0]          res_index_reg, res_index_next;
    logic [FIELD_BITS-1:0]  res_offset_reg, res_offset_next;
    status_t                status_reg;
    logic [INDEX_BITS-1:0]  index_reg;
    logic [FIELD_BITS-1:0]  offset_reg;
    logic                   out_load;
    logic [IW+INDEX_BITS-1:0] index_wide;

    logic                   wr_en;
    logic [FIELD_BITS-1:0]  masked_addr;
    logic [FIELD_BITS-1:0]  rd_data;
    logic [IW-1:0]          rd_addr;
    logic [IW-1:0]          hit_index;
    logic                   table_full;
    search_ctl_t            search_ctl;
    search_sts_t            search_sts;

    assign masked_addr = addr_value & ADDR_MASK;
    assign table_full  = (total_reg == CW'(TABLE_DEPTH));

    // start address store; appends happen only between lookups, so no
    // read and write of the same entry overlap
    sapl_ram #(
        .WIDTH (FIELD_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (total_reg[IW-1:0]),
        .wr_data (masked_addr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sapl_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (search_ctl),
        .total     (total_reg),
        .key       (key_next),
        .rd_data   (rd_data),
        .sts       (search_sts),
        .rd_addr   (rd_addr),
        .hit_index (hit_index)
    );

    // output register is free when empty or being taken
    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);

    // sequencer: next state and controls
    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_offset_next = res_offset_reg;
        wr_en           = 1'b0;
        in_ready        = 1'b0;
        search_ctl      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next        = masked_addr;
                    res_status_next = STAT_DONE;
                    res_index_next  = '0;
                    res_offset_next = '0;
                    state_next      = ST_RESULT;
                    unique case (func_t'(func))
                        FUNC_APPEND:
                        begin
                            if (table_full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                total_next = total_reg + CW'(1);
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            search_ctl.start = 1'b1;
                            if (search_sts.more)
                            begin
                                state_next = ST_PROBE;
                            end
                            else
                            begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            total_next = '0;
                        end
                        default:
                        begin
                            // unused code: table unchanged, done status returned
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                search_ctl.step = 1'b1;
                if (!search_sts.more)
                begin
                    if (search_sts.lo_zero)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                res_status_next = STAT_FOUND;
                res_index_next  = hit_index;
                res_offset_next = key_reg - rd_data;
                state_next      = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output valid: set on load, cleared when taken
    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    // result index fitted to the port width
    assign index_wide = {{INDEX_BITS{1'b0}}, res_index_reg};

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_offset_reg <= res_offset_next;
        if (out_load)
        begin
            status_reg <= res_status_reg;
            index_reg  <= index_wide[INDEX_BITS-1:0];
            offset_reg <= res_offset_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_index  = index_reg;
    assign entry_offset = offset_reg;

endmodule

/* design/sapl_checker.sv */
// port-level checker for the sorted address predecessor lookup, with its bind
`include "sorted_address_predecessor_lookup_macros.svh"

module sapl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [1:0]                      status,
    input logic [sapl_pkg::INDEX_BITS-1:0] entry_index,
    input logic [sapl_pkg::FIELD_BITS-1:0] entry_offset
);
    import sapl_pkg::*;

    // a stalled result holds its payload
    `SAPL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(entry_index) && $stable(entry_offset), "stalled result changed")

    // one transaction at a time: busy right after acceptance
    `SAPL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while a transaction is in flight")

    // index and offset are zero unless an entry was found
    `SAPL_ASSERT_NOW(a_zero_fields, out_valid && (status != STAT_FOUND), (entry_index == '0) && (entry_offset == '0), "non-zero fields on a result without a match")

    // with the output empty at acceptance, no result is ready in the cycle after it
    `SAPL_ASSERT_NEXT(a_no_early_result, in_valid && in_ready && !out_valid, !out_valid, "result appeared one cycle after acceptance")

endmodule

bind sorted_address_predecessor_lookup sapl_checker u_sapl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .entry_index  (entry_index),
    .entry_offset (entry_offset)
);

/* tb/tb_top.sv */
// self-checking testbench for the sorted address predecessor lookup block
module tb_top;
    import sapl_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int ITEM_TARGET  = 1450;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        status_t                st;
        logic [INDEX_BITS-1:0]  idx;
        logic [FIELD_BITS-1:0]  off;
    } outcome_t;

    typedef struct packed {
        logic [1:0]             f;
        logic [FIELD_BITS-1:0]  a;
        logic                   typed;
        outcome_t               want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             func = 2'd0;
    logic [FIELD_BITS-1:0]  addr_value = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             status;
    logic [INDEX_BITS-1:0]  entry_index;
    logic [FIELD_BITS-1:0]  entry_offset;

    // shadow copy of the start table and entry count
    logic [FIELD_BITS-1:0]  shadow_starts [TABLE_DEPTH];
    logic [10:0]            shadow_total = '0;

    outcome_t               pending_outcomes [$];
    stim_row_t              dir_rows [$];
    int                     fail_count = 0;
    int                     item_count = 0;
    int                     idle_cycles = 0;
    bit                     no_idle = 1'b0;
    bit                     hold_off_req = 1'b0;

    sorted_address_predecessor_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (32)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .addr_value   (addr_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .entry_index  (entry_index),
        .entry_offset (entry_offset)
    );

    // clock
    always #6 clk = ~clk;

    // predicted result of one transaction, updating the shadow table
    function automatic outcome_t predict_outcome(input logic [1:0] f,
                                                 input logic [FIELD_BITS-1:0] a);
        outcome_t    r;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        r = '0;
        r.st = STAT_DONE;
        case (f)
            FUNC_APPEND:
            begin
                if (shadow_total >= TABLE_DEPTH)
                    r.st = STAT_FULL;
                else
                begin
                    shadow_starts[shadow_total] = a;
                    shadow_total = shadow_total + 11'd1;
                end
            end
            FUNC_LOOKUP:
            begin
                lo = 0;
                hi = shadow_total;
                if (hi > TABLE_DEPTH)
                    hi = TABLE_DEPTH;
                // upper-bound search over whatever is stored
                while (lo < hi)
                begin
                    mid = lo + ((hi - lo) >> 1);
                    if (shadow_starts[mid] <= a)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo == 0)
                    r.st = STAT_NOT_FOUND;
                else
                begin
                    r.st = STAT_FOUND;
                    r.idx = INDEX_BITS'(lo - 1);
                    r.off = a - shadow_starts[lo - 1];
                end
            end
            FUNC_CLEAR:
                shadow_total = '0;
            default:
                ;
        endcase
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(input logic [1:0] f, input logic [FIELD_BITS-1:0] a,
                           input logic typed, input status_t st,
                           input logic [INDEX_BITS-1:0] idx,
                           input logic [FIELD_BITS-1:0] off);
        stim_row_t row;
        row.f = f;
        row.a = a;
        row.typed = typed;
        row.want.st = st;
        row.want.idx = idx;
        row.want.off = off;
        dir_rows.push_back(row);
    endtask

    // offer one transaction after a random gap and wait for acceptance
    task automatic drive_item(input logic [1:0] f, input logic [FIELD_BITS-1:0] a,
                              input logic typed, input outcome_t want);
        int       gap;
        outcome_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        addr_value <= a;
        do
            @(posedge clk);
        while (!in_ready);
        pred = predict_outcome(f, a);
        pending_outcomes.push_back(typed ? want : pred);
        if (f != FUNC_UNUSED)
            item_count++;
    endtask

    // compare one result transaction with the oldest expectation
    task automatic check_result();
        outcome_t want;
        if (pending_outcomes.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual status %0d index %0d offset %h",
                     $time, status, entry_index, entry_offset);
            fail_count++;
        end
        else
        begin
            want = pending_outcomes.pop_front();
            if (status !== want.st)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.st, status);
                fail_count++;
            end
            if (entry_index !== want.idx)
            begin
                $display("%0t: entry_index mismatch: expected %0d, actual %0d",
                         $time, want.idx, entry_index);
                fail_count++;
            end
            if (entry_offset !== want.off)
            begin
                $display("%0t: entry_offset mismatch: expected %h, actual %h",
                         $time, want.off, entry_offset);
                fail_count++;
            end
        end
    endtask

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial
    begin : receiver
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_result();
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    out_ready <= 1'b0;
                    stall_left--;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted transaction or taken result
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin : sender
        logic [FIELD_BITS-1:0] seq_starts [$];
        logic [FIELD_BITS-1:0] base;
        logic [FIELD_BITS-1:0] step;
        logic [FIELD_BITS-1:0] q;
        int                    n;
        int                    m;
        int                    j;

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: empty table, bounds, unused code, clear, unsorted load
        add_row(FUNC_LOOKUP, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, '0, '0);
        add_row(FUNC_LOOKUP, 32'hffff_ffff, 1'b1, STAT_NOT_FOUND, '0, '0);
        add_row(FUNC_UNUSED, 32'h1234_5678, 1'b1, STAT_DONE, '0, '0);
        add_row(FUNC_APPEND, 32'h0000_1000, 1'b1, STAT_DONE, '0, '0);
        add_row(FUNC_APPEND, 32'h0000_2000, 1'b1, STAT_DONE, '0, '0);
        add_row(FUNC_LOOKUP, 32'h0000_0fff, 1'b1, STAT_NOT_FOUND, '0, '0);
        add_row(FUNC_LOOKUP, 32'h0000_1000, 1'b1, STAT_FOUND, 10'd0, 32'h0);
        add_row(FUNC_LOOKUP, 32'h0000_1abc, 1'b1, STAT_FOUND, 10'd0, 32'h0abc);
        add_row(FUNC_LOOKUP, 32'h0000_2000, 1'b1, STAT_FOUND, 10'd1, 32'h0);
        add_row(FUNC_LOOKUP, 32'hffff_ffff, 1'b1, STAT_FOUND, 10'd1, 32'hffff_dfff);
        add_row(FUNC_APPEND, 32'hffff_ffff, 1'b1, STAT_DONE, '0, '0);
        add_row(FUNC_LOOKUP, 32'hffff_ffff, 1'b1, STAT_FOUND, 10'd2, 32'h0);
        add_row(FUNC_LOOKUP, 32'hffff_fffe, 1'b0, STAT_DONE, '0, '0);
        add_row(FUNC_CLEAR, 32'hdead_beef, 1'b1, STAT_DONE, '0, '0);
        add_row(FUNC_LOOKUP, 32'h0000_1000, 1'b1, STAT_NOT_FOUND, '0, '0);
        add_row(FUNC_APPEND, 32'h0000_0000, 1'b1, STAT_DONE, '0, '0);
        add_row(FUNC_LOOKUP, 32'h0000_0000, 1'b1, STAT_FOUND, 10'd0, 32'h0);
        add_row(FUNC_LOOKUP, 32'hffff_ffff, 1'b1, STAT_FOUND, 10'd0, 32'hffff_ffff);
        add_row(FUNC_APPEND, 32'h8000_0000, 1'b0, STAT_DONE, '0, '0);
        add_row(FUNC_APPEND, 32'h4000_0000, 1'b0, STAT_DONE, '0, '0);
        add_row(FUNC_APPEND, 32'h7fff_ffff, 1'b0, STAT_DONE, '0, '0);
        add_row(FUNC_LOOKUP, 32'h5000_0000, 1'b0, STAT_DONE, '0, '0);
        add_row(FUNC_LOOKUP, 32'h9000_0000, 1'b0, STAT_DONE, '0, '0);
        add_row(FUNC_UNUSED, 32'hffff_ffff, 1'b1, STAT_DONE, '0, '0);
        add_row(FUNC_CLEAR, 32'h0000_0000, 1'b1, STAT_DONE, '0, '0);
        foreach (dir_rows[i])
            drive_item(dir_rows[i].f, dir_rows[i].a, dir_rows[i].typed, dir_rows[i].want);

        // fill the table to capacity, receiver holding off at the start
        drive_item(FUNC_CLEAR, $urandom, 1'b0, '0);
        hold_off_req = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            drive_item(FUNC_APPEND, {i[9:0], 22'($urandom_range(0, 32'h3f_ffff))},
                       1'b0, '0);
            if (i % 64 == 63)
                drive_item(FUNC_LOOKUP, $urandom, 1'b0, '0);
        end
        // appends to a full table are dropped
        repeat (3) drive_item(FUNC_APPEND, $urandom, 1'b0, '0);
        drive_item(FUNC_LOOKUP, 32'h0000_0000, 1'b0, '0);
        drive_item(FUNC_LOOKUP, 32'hffff_ffff, 1'b0, '0);
        repeat (20) drive_item(FUNC_LOOKUP, $urandom, 1'b0, '0);

        // random part: mostly sorted loads followed by lookups, some noise
        while (item_count < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 4) != 0)
            begin
                drive_item(FUNC_CLEAR, $urandom, 1'b0, '0);
                seq_starts.delete();
                n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
                base = $urandom_range(0, 32'hf000_0000);
                step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                   : $urandom_range(1, 32'h3f_ffff);
                for (int k = 0; k < n; k++)
                begin
                    seq_starts.push_back(base);
                    drive_item(FUNC_APPEND, base, 1'b0, '0);
                    base = base + step;
                end
                m = $urandom_range(1, 20);
                for (int k = 0; k < m; k++)
                begin
                    j = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 5))
                        0: q = seq_starts[j];
                        1: q = seq_starts[j] + $urandom_range(0, 15);
                        2: q = (seq_starts[0] == '0) ? '0 : seq_starts[0] - 1;
                        3: q = $urandom;
                        4: q = 32'hffff_ffff;
                        default: q = seq_starts[j] + $urandom;
                    endcase
                    drive_item(FUNC_LOOKUP, q, 1'b0, '0);
                end
            end
            else
                repeat ($urandom_range(1, 8))
                    drive_item(2'($urandom_range(0, 3)), $urandom, 1'b0, '0);
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        // drain and settle
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/sapl_pkg.sv
design/sapl_ram.sv
design/sapl_search.sv
design/sorted_address_predecessor_lookup.sv
design/sapl_checker.sv
tb/tb_top.sv
